// ===== hdl/tmcr_pkg.sv =====
// Shared types, constants and defaults of the tile map collision resolver.
`default_nettype none

package tmcr_pkg;

    // Fixed field widths of the channels.
    localparam int POS_W   = 24;
    localparam int AGENT_W = 14;
    localparam int MSIZE_W = 7;
    localparam int CELL_W  = 6;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 14;

    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    // Defaults of the top-level parameters.
    localparam int DEF_MAP_COLS       = 64;
    localparam int DEF_MAP_ROWS       = 64;
    localparam int DEF_TILE_SIZE_LOG2 = 6;

    // Register values after reset.
    localparam logic [AGENT_W-1:0] SIDE_LEN_RST    = AGENT_W'(15360);
    localparam logic [MSIZE_W-1:0] MAP_COLUMNS_RST = MSIZE_W'(64);
    localparam logic [MSIZE_W-1:0] MAP_ROWS_RST    = MSIZE_W'(64);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SIDE_LEN    = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAP_COLUMNS = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAP_ROWS    = 2'd2;

    typedef enum logic {
        OP_WRITE_CELL = 1'b0,
        OP_RESOLVE    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_LOOK,
        ST_TEST,
        ST_DEPTH,
        ST_PUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       cell_wr;
        logic       clear_wr;
        logic       look;
        logic [1:0] corner;
        logic       measure;
        logic       depth;
        logic       push;
        logic       emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_resolve;
        logic clear_last;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/tmcr_channels.sv =====
// Channel interfaces of the tile map collision resolver.
`default_nettype none

interface tmcr_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [tmcr_pkg::CELL_W-1:0]      cell_column;
    logic [tmcr_pkg::CELL_W-1:0]      cell_row;
    logic                             cell_solid;
    logic signed [tmcr_pkg::POS_W-1:0] pos_x;
    logic signed [tmcr_pkg::POS_W-1:0] pos_y;

    modport source (output valid, operation, cell_column, cell_row, cell_solid,
                    pos_x, pos_y, input ready);
    modport sink   (input valid, operation, cell_column, cell_row, cell_solid,
                    pos_x, pos_y, output ready);
endinterface

interface tmcr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tmcr_pkg::POS_W-1:0] new_x;
    logic signed [tmcr_pkg::POS_W-1:0] new_y;
    logic                             collided;

    modport source (output valid, new_x, new_y, collided, input ready);
    modport sink   (input valid, new_x, new_y, collided, output ready);
endinterface

interface tmcr_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [tmcr_pkg::IDX_W-1:0]   index;
    logic [tmcr_pkg::DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tmcr_ctrl.sv =====
// Sequencing state machine of the tile map collision resolver.
`default_nettype none

module tmcr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tmcr_pkg::dp_status_t status,
    output tmcr_pkg::ctrl_cmd_t       cmd
);

    tmcr_pkg::state_t state_reg, state_next;
    logic [1:0]       corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tmcr_pkg::ST_CLEAR;
            corner_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        cmd         = '0;
        cmd.corner  = corner_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            tmcr_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                    state_next = tmcr_pkg::ST_IDLE;
            end
            tmcr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    corner_next = 2'd0;
                    state_next  = status.in_resolve ? tmcr_pkg::ST_LOOK
                                                    : tmcr_pkg::ST_WRITE;
                end
            end
            tmcr_pkg::ST_WRITE:
            begin
                cmd.cell_wr = 1'b1;
                state_next  = tmcr_pkg::ST_DONE;
            end
            tmcr_pkg::ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = tmcr_pkg::ST_TEST;
            end
            tmcr_pkg::ST_TEST:
            begin
                if (status.hit)
                begin
                    cmd.measure = 1'b1;
                    state_next  = tmcr_pkg::ST_DEPTH;
                end
                else if (corner_reg == 2'd3)
                    state_next = tmcr_pkg::ST_DONE;
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = tmcr_pkg::ST_LOOK;
                end
            end
            tmcr_pkg::ST_DEPTH:
            begin
                cmd.depth  = 1'b1;
                state_next = tmcr_pkg::ST_PUSH;
            end
            tmcr_pkg::ST_PUSH:
            begin
                cmd.push = 1'b1;
                if (corner_reg == 2'd3)
                    state_next = tmcr_pkg::ST_DONE;
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = tmcr_pkg::ST_LOOK;
                end
            end
            tmcr_pkg::ST_DONE:
            begin
                // The result waits here only while the output register is full.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tmcr_pkg::ST_IDLE;
                end
            end
            default:
                state_next = tmcr_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tmcr_dp.sv =====
// Datapath of the tile map collision resolver: registers, tile map and push-out unit.
`default_nettype none

module tmcr_dp #(
    parameter int MAP_COLS       = tmcr_pkg::DEF_MAP_COLS,
    parameter int MAP_ROWS       = tmcr_pkg::DEF_MAP_ROWS,
    parameter int TILE_SIZE_LOG2 = tmcr_pkg::DEF_TILE_SIZE_LOG2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tmcr_pkg::ctrl_cmd_t               cmd,
    output tmcr_pkg::dp_status_t                   status,
    input  wire logic                              in_operation,
    input  wire logic [tmcr_pkg::CELL_W-1:0]       in_cell_column,
    input  wire logic [tmcr_pkg::CELL_W-1:0]       in_cell_row,
    input  wire logic                              in_cell_solid,
    input  wire logic signed [tmcr_pkg::POS_W-1:0] in_pos_x,
    input  wire logic signed [tmcr_pkg::POS_W-1:0] in_pos_y,
    input  wire logic                              cfg_we,
    input  wire logic [tmcr_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [tmcr_pkg::DATA_W-1:0]       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [tmcr_pkg::POS_W-1:0]      out_new_x,
    output logic signed [tmcr_pkg::POS_W-1:0]      out_new_y,
    output logic                                   out_collided
);

    localparam int POS_W = tmcr_pkg::POS_W;
    localparam int AGW   = tmcr_pkg::AGENT_W;
    localparam int S     = TILE_SIZE_LOG2 + 8;
    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int RIW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int IW    = (CIW > RIW) ? CIW : RIW;
    localparam int DW    = (IW + S + 3 > 28) ? IW + S + 3 : 28;
    localparam int PW    = POS_W + 1;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DW-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > $signed(DW'(tmcr_pkg::POS_MAX)))
            r = POS_W'(tmcr_pkg::POS_MAX);
        else if (v < $signed(DW'(tmcr_pkg::POS_MIN)))
            r = POS_W'(tmcr_pkg::POS_MIN);
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    // Configuration registers.
    logic [AGW-1:0]               side_len_reg;
    logic [tmcr_pkg::MSIZE_W-1:0] map_columns_reg;
    logic [tmcr_pkg::MSIZE_W-1:0] map_rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_len_reg    <= tmcr_pkg::SIDE_LEN_RST;
            map_columns_reg <= tmcr_pkg::MAP_COLUMNS_RST;
            map_rows_reg    <= tmcr_pkg::MAP_ROWS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tmcr_pkg::REG_SIDE_LEN: side_len_reg <= cfg_data[AGW-1:0];
                tmcr_pkg::REG_MAP_COLUMNS:
                    map_columns_reg <= cfg_data[tmcr_pkg::MSIZE_W-1:0];
                tmcr_pkg::REG_MAP_ROWS:
                    map_rows_reg <= cfg_data[tmcr_pkg::MSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched input word.
    logic                     op_reg;
    logic [tmcr_pkg::CELL_W-1:0] cell_col_reg, cell_row_reg;
    logic                     cell_solid_reg;
    logic signed [POS_W-1:0]  orig_x_reg, orig_y_reg;
    logic signed [POS_W-1:0]  cur_x_reg, cur_y_reg;
    logic                     collided_reg;

    // Tile map memory and its clearing counter.
    logic          tile_mem [DEPTH];
    logic [AW-1:0] clear_idx_reg;
    logic          rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic          mem_wd;
    logic [AW-1:0] cell_addr;
    logic          cell_ok;

    // Corner lookup.
    logic signed [PW-1:0] px, py, tcs, trs;
    logic                 in_map_c;
    logic [AW-1:0]        rd_addr;
    logic                 in_map_reg;
    logic [CIW-1:0]       tc_reg;
    logic [RIW-1:0]       tr_reg;

    // Push-out unit.
    logic signed [DW-1:0] xs, ys, dx2_c, dy2_c, dx2_reg, dy2_reg;
    logic signed [DW-1:0] min2, absx, absy, xd2_reg, yd2_reg;
    logic signed [DW-1:0] sumx, sumy;
    logic                 dxneg_reg, dyneg_reg;
    logic                 both_pos, push_x, push_y;

    always_comb
    begin
        cell_ok   = (32'(cell_col_reg) < MAP_COLS) && (32'(cell_row_reg) < MAP_ROWS);
        cell_addr = AW'(AW'(cell_row_reg) * AW'(MAP_COLS)) + AW'(cell_col_reg);
        mem_we    = cmd.clear_wr || (cmd.cell_wr && cell_ok);
        mem_wa    = cmd.clear_wr ? clear_idx_reg : cell_addr;
        mem_wd    = cmd.clear_wr ? 1'b0 : cell_solid_reg;
    end

    always_comb
    begin
        px = {orig_x_reg[POS_W-1], orig_x_reg}
             + (cmd.corner[0] ? PW'(side_len_reg) : PW'(0));
        py = {orig_y_reg[POS_W-1], orig_y_reg}
             + (cmd.corner[1] ? PW'(side_len_reg) : PW'(0));
        // Floor division by the tile size is an arithmetic shift.
        tcs = px >>> S;
        trs = py >>> S;
        in_map_c = !px[PW-1] && !py[PW-1]
                   && (tcs < $signed(PW'(map_columns_reg)))
                   && (tcs < $signed(PW'(MAP_COLS)))
                   && (trs < $signed(PW'(map_rows_reg)))
                   && (trs < $signed(PW'(MAP_ROWS)));
        rd_addr = AW'(AW'(trs[RIW-1:0]) * AW'(MAP_COLS)) + AW'(tcs[CIW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tile_mem[mem_wa] <= mem_wd;
        if (cmd.look)
            rd_data_reg <= tile_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_idx_reg <= '0;
        else if (cmd.clear_wr)
            clear_idx_reg <= clear_idx_reg + AW'(1);
    end

    // Distances are kept at doubled scale, where they are even only when the side length is even.
    always_comb
    begin
        xs    = DW'(cur_x_reg);
        ys    = DW'(cur_y_reg);
        dx2_c = (xs <<< 1) + $signed(DW'(side_len_reg))
                - $signed(DW'({tc_reg, 1'b1}) << S);
        dy2_c = (ys <<< 1) + $signed(DW'(side_len_reg))
                - $signed(DW'({tr_reg, 1'b1}) << S);
        min2  = $signed(DW'(side_len_reg) + (DW'(1) << S));
        absx  = dx2_reg[DW-1] ? -dx2_reg : dx2_reg;
        absy  = dy2_reg[DW-1] ? -dy2_reg : dy2_reg;
        both_pos = (xd2_reg > $signed(DW'(0))) && (yd2_reg > $signed(DW'(0)));
        push_x   = both_pos && (xd2_reg < yd2_reg);
        push_y   = both_pos && !(xd2_reg < yd2_reg);
        sumx = dxneg_reg ? xs - (xd2_reg >>> 1) : xs + (xd2_reg >>> 1);
        sumy = dyneg_reg ? ys - (yd2_reg >>> 1) : ys + (yd2_reg >>> 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= in_operation;
            cell_col_reg   <= in_cell_column;
            cell_row_reg   <= in_cell_row;
            cell_solid_reg <= in_cell_solid;
            orig_x_reg     <= in_pos_x;
            orig_y_reg     <= in_pos_y;
            cur_x_reg      <= in_pos_x;
            cur_y_reg      <= in_pos_y;
            collided_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.measure)
                collided_reg <= 1'b1;
            if (cmd.push && push_x)
                cur_x_reg <= sat_pos(sumx);
            if (cmd.push && push_y)
                cur_y_reg <= sat_pos(sumy);
        end
        if (cmd.look)
        begin
            in_map_reg <= in_map_c;
            tc_reg     <= tcs[CIW-1:0];
            tr_reg     <= trs[RIW-1:0];
        end
        if (cmd.measure)
        begin
            dx2_reg <= dx2_c;
            dy2_reg <= dy2_c;
        end
        if (cmd.depth)
        begin
            xd2_reg   <= min2 - absx;
            yd2_reg   <= min2 - absy;
            dxneg_reg <= dx2_reg[DW-1];
            dyneg_reg <= dy2_reg[DW-1];
        end
    end

    // Output register: it takes a new word once the previous one has left.
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_x_reg, out_y_reg;
    logic                    out_coll_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg    <= (op_reg == tmcr_pkg::OP_RESOLVE) ? cur_x_reg : '0;
            out_y_reg    <= (op_reg == tmcr_pkg::OP_RESOLVE) ? cur_y_reg : '0;
            out_coll_reg <= (op_reg == tmcr_pkg::OP_RESOLVE) && collided_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_new_x    = out_x_reg;
    assign out_new_y    = out_y_reg;
    assign out_collided = out_coll_reg;

    assign status.in_resolve = (in_operation == tmcr_pkg::OP_RESOLVE);
    assign status.clear_last = (clear_idx_reg == AW'(DEPTH - 1));
    assign status.hit        = rd_data_reg && in_map_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ===== hdl/tile_map_collision_resolver_core.sv =====
// Top level of the tile map collision resolver.
// The req channel carries one word per operation: a map cell write
// (cell_column, cell_row, cell_solid) or a resolve of an agent position
// (pos_x, pos_y, signed Q8). Every accepted word yields exactly one rsp word;
// a cell write answers with new_x, new_y and collided all zero.
// The cfg channel writes the agent side length, map_columns and map_rows by
// index; it is always ready and should be used only while the block is idle.
// A resolve steps through the four corners one at a time: each needs a tile
// map read (LOOK, then TEST), and a corner in a solid tile also passes DEPTH
// and PUSH in the single shared push-out unit. A cell write passes WRITE and DONE.
// One word is worked on at a time; req.ready is high while the block waits for
// work, so a new word is taken only once the last one is through. The result
// sits in an output register, so a stalled receiver does not keep the block
// from taking the next word; that word only waits at the end until the
// register frees up.
// After reset the tile map is cleared one cell per cycle, all MAP_COLS * MAP_ROWS
// cells (4096 by default), during which req.ready stays low; cfg writes are
// still taken.
`default_nettype none

module tile_map_collision_resolver_core #(
    parameter int MAP_COLS       = tmcr_pkg::DEF_MAP_COLS,
    parameter int MAP_ROWS       = tmcr_pkg::DEF_MAP_ROWS,
    parameter int TILE_SIZE_LOG2 = tmcr_pkg::DEF_TILE_SIZE_LOG2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tmcr_in_if.sink    req,
    tmcr_out_if.source rsp,
    tmcr_cfg_if.sink   cfg
);

    tmcr_pkg::ctrl_cmd_t  cmd;
    tmcr_pkg::dp_status_t status;
    logic                 in_ready;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    tmcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tmcr_dp #(
        .MAP_COLS       (MAP_COLS),
        .MAP_ROWS       (MAP_ROWS),
        .TILE_SIZE_LOG2 (TILE_SIZE_LOG2)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_operation   (req.operation),
        .in_cell_column (req.cell_column),
        .in_cell_row    (req.cell_row),
        .in_cell_solid  (req.cell_solid),
        .in_pos_x       (req.pos_x),
        .in_pos_y       (req.pos_y),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_new_x      (rsp.new_x),
        .out_new_y      (rsp.new_y),
        .out_collided   (rsp.collided)
    );

endmodule

`default_nettype wire

// ===== bench/tmcr_resolve_monitor.sv =====
`timescale 1ns / 1ps
// Channel monitor that predicts every response word of the resolver and compares it.
module tmcr_resolve_monitor (
    input  wire logic clk,
    input  wire logic rst_n,
    tmcr_in_if        req,
    tmcr_out_if       rsp,
    tmcr_cfg_if       cfg,
    output int        mismatches,
    output int        outstanding
);

    localparam int COLS       = tmcr_pkg::DEF_MAP_COLS;
    localparam int ROWS       = tmcr_pkg::DEF_MAP_ROWS;
    localparam int TILE_SHIFT = tmcr_pkg::DEF_TILE_SIZE_LOG2 + 8;

    typedef struct packed {
        logic signed [tmcr_pkg::POS_W-1:0] new_x;
        logic signed [tmcr_pkg::POS_W-1:0] new_y;
        logic                              collided;
    } placement_t;

    bit                           solid_map [COLS*ROWS];
    logic [tmcr_pkg::AGENT_W-1:0] side_len;
    logic [tmcr_pkg::MSIZE_W-1:0] map_columns;
    logic [tmcr_pkg::MSIZE_W-1:0] map_rows;
    placement_t                   predicted_moves [$];
    placement_t                   oldest;

    function automatic longint clamp_pos(longint v);
        if (v > tmcr_pkg::POS_MAX)
            return tmcr_pkg::POS_MAX;
        if (v < tmcr_pkg::POS_MIN)
            return tmcr_pkg::POS_MIN;
        return v;
    endfunction

    function automatic placement_t push_out(logic signed [tmcr_pkg::POS_W-1:0] pos_x,
                                            logic signed [tmcr_pkg::POS_W-1:0] pos_y);
        longint     tile;
        longint     cols_used;
        longint     rows_used;
        longint     w;
        longint     x;
        longint     y;
        longint     corner_x;
        longint     corner_y;
        longint     tc;
        longint     tr;
        longint     min2;
        longint     dx2;
        longint     dy2;
        longint     xd2;
        longint     yd2;
        longint     hit_col [4];
        longint     hit_row [4];
        int         hits;
        int         i;
        placement_t res;
        tile      = longint'(1) << TILE_SHIFT;
        cols_used = (longint'(map_columns) < COLS) ? longint'(map_columns) : COLS;
        rows_used = (longint'(map_rows) < ROWS) ? longint'(map_rows) : ROWS;
        w         = longint'(side_len);
        x         = longint'(pos_x);
        y         = longint'(pos_y);
        hits      = 0;
        // Corners are taken from the original position; the shift gives floor division.
        for (i = 0; i < 4; i++)
        begin
            corner_x = x + (i[0] ? w : 0);
            corner_y = y + (i[1] ? w : 0);
            tc = corner_x >>> TILE_SHIFT;
            tr = corner_y >>> TILE_SHIFT;
            if (tc >= 0 && tc < cols_used && tr >= 0 && tr < rows_used &&
                solid_map[tr * COLS + tc])
            begin
                hit_col[hits] = tc;
                hit_row[hits] = tr;
                hits++;
            end
        end
        // Depths are kept at doubled scale, where they are even only when the side length is even.
        min2 = w + tile;
        for (i = 0; i < hits; i++)
        begin
            dx2 = 2 * x + w - (2 * hit_col[i] * tile + tile);
            dy2 = 2 * y + w - (2 * hit_row[i] * tile + tile);
            xd2 = min2 - ((dx2 < 0) ? -dx2 : dx2);
            yd2 = min2 - ((dy2 < 0) ? -dy2 : dy2);
            if (xd2 > 0 && yd2 > 0)
            begin
                if (xd2 < yd2)
                    x = clamp_pos((dx2 < 0) ? x - xd2 / 2 : x + xd2 / 2);
                else
                    y = clamp_pos((dy2 < 0) ? y - yd2 / 2 : y + yd2 / 2);
            end
        end
        res.new_x    = x[tmcr_pkg::POS_W-1:0];
        res.new_y    = y[tmcr_pkg::POS_W-1:0];
        res.collided = (hits > 0);
        return res;
    endfunction

    task automatic flag_mismatch(string what, placement_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected x=%0d y=%0d collided=%0b, got x=%0d y=%0d collided=%0b",
                     $time, what, $signed(want.new_x), $signed(want.new_y), want.collided,
                     $signed(rsp.new_x), $signed(rsp.new_y), rsp.collided);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (solid_map[k])
                solid_map[k] = 1'b0;
            side_len    = tmcr_pkg::SIDE_LEN_RST;
            map_columns = tmcr_pkg::MAP_COLUMNS_RST;
            map_rows    = tmcr_pkg::MAP_ROWS_RST;
            predicted_moves.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    tmcr_pkg::REG_SIDE_LEN:
                        side_len = cfg.data[tmcr_pkg::AGENT_W-1:0];
                    tmcr_pkg::REG_MAP_COLUMNS:
                        map_columns = cfg.data[tmcr_pkg::MSIZE_W-1:0];
                    tmcr_pkg::REG_MAP_ROWS:
                        map_rows = cfg.data[tmcr_pkg::MSIZE_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.operation == tmcr_pkg::OP_WRITE_CELL)
                begin
                    solid_map[int'(req.cell_row) * COLS + int'(req.cell_column)] = req.cell_solid;
                    predicted_moves = {predicted_moves, placement_t'('0)};
                end
                else
                    predicted_moves = {predicted_moves, push_out(req.pos_x, req.pos_y)};
            end
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_moves.size() == 0)
                    flag_mismatch("response word with nothing pending", '0);
                else
                begin
                    oldest = predicted_moves.pop_front();
                    if (rsp.new_x !== oldest.new_x || rsp.new_y !== oldest.new_y ||
                        rsp.collided !== oldest.collided)
                        flag_mismatch("response word differs", oldest);
                end
            end
            outstanding = predicted_moves.size();
        end
    end
endmodule

// ===== bench/tile_map_collision_resolver_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the tile map collision resolver: stimulus, idling and the verdict.
module tile_map_collision_resolver_core_tb;

    localparam int TILE_Q8     = 1 << (tmcr_pkg::DEF_TILE_SIZE_LOG2 + 8);
    localparam logic [tmcr_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE      = 30;
    localparam int PHASE_WORDS = 150;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    bit   gaps_on;
    bit   stalls_on;
    int   cols_now;
    int   rows_now;
    int   win_col;
    int   win_row;
    int   phase;

    tmcr_in_if  req ();
    tmcr_out_if rsp ();
    tmcr_cfg_if cfg ();

    tile_map_collision_resolver_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    tmcr_resolve_monitor resolve_mon (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver side: ready drops in random bursts while stalls are enabled.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stalls_on && $urandom_range(0, 2) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Valid stays high after a handshake; the next word or a gap takes over from there.
    task automatic send_word(tmcr_pkg::op_t op, logic [tmcr_pkg::CELL_W-1:0] col,
                             logic [tmcr_pkg::CELL_W-1:0] row, logic solid,
                             logic signed [tmcr_pkg::POS_W-1:0] px,
                             logic signed [tmcr_pkg::POS_W-1:0] py);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.operation   <= op;
        req.cell_column <= col;
        req.cell_row    <= row;
        req.cell_solid  <= solid;
        req.pos_x       <= px;
        req.pos_y       <= py;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic write_cell(int col, int row, bit solid);
        send_word(tmcr_pkg::OP_WRITE_CELL, tmcr_pkg::CELL_W'(col), tmcr_pkg::CELL_W'(row),
                  solid, tmcr_pkg::POS_W'($urandom()), tmcr_pkg::POS_W'($urandom()));
    endtask

    task automatic resolve(int px, int py);
        send_word(tmcr_pkg::OP_RESOLVE, tmcr_pkg::CELL_W'($urandom()),
                  tmcr_pkg::CELL_W'($urandom()), 1'($urandom()),
                  tmcr_pkg::POS_W'(px), tmcr_pkg::POS_W'(py));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [tmcr_pkg::IDX_W-1:0] idx,
                             logic [tmcr_pkg::DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    task automatic apply_setting(int w, logic [tmcr_pkg::DATA_W-1:0] col_data,
                                 logic [tmcr_pkg::DATA_W-1:0] row_data, bit poke_unused);
        write_reg(tmcr_pkg::REG_SIDE_LEN, tmcr_pkg::DATA_W'(w));
        write_reg(tmcr_pkg::REG_MAP_COLUMNS, col_data);
        write_reg(tmcr_pkg::REG_MAP_ROWS, row_data);
        if (poke_unused)
            write_reg(REG_UNUSED, tmcr_pkg::DATA_W'($urandom()));
        cfg.valid <= 1'b0;
        cols_now  = (int'(col_data[tmcr_pkg::MSIZE_W-1:0]) < tmcr_pkg::DEF_MAP_COLS) ?
                    int'(col_data[tmcr_pkg::MSIZE_W-1:0]) : tmcr_pkg::DEF_MAP_COLS;
        rows_now  = (int'(row_data[tmcr_pkg::MSIZE_W-1:0]) < tmcr_pkg::DEF_MAP_ROWS) ?
                    int'(row_data[tmcr_pkg::MSIZE_W-1:0]) : tmcr_pkg::DEF_MAP_ROWS;
        win_col   = (cols_now > 4) ? $urandom_range(0, cols_now - 4) : 0;
        win_row   = (rows_now > 4) ? $urandom_range(0, rows_now - 4) : 0;
    endtask

    // Most words work a small window of the map so that resolves hit solid tiles often.
    task automatic random_word();
        int roll;
        int x;
        int y;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            write_cell(win_col + $urandom_range(0, 3), win_row + $urandom_range(0, 3),
                       $urandom_range(0, 3) != 0);
        else if (roll < 35)
            write_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom()));
        else if (roll < 90)
        begin
            x = (win_col - 1) * TILE_Q8 + int'($urandom_range(0, 6 * TILE_Q8));
            y = (win_row - 1) * TILE_Q8 + int'($urandom_range(0, 6 * TILE_Q8));
            resolve(x, y);
        end
        else
            resolve(int'($urandom()), int'($urandom()));
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.operation   = tmcr_pkg::OP_WRITE_CELL;
        req.cell_column = '0;
        req.cell_row    = '0;
        req.cell_solid  = 1'b0;
        req.pos_x       = '0;
        req.pos_y       = '0;
        cfg.valid       = 1'b0;
        cfg.index       = tmcr_pkg::REG_SIDE_LEN;
        cfg.data        = '0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        cols_now        = tmcr_pkg::DEF_MAP_COLS;
        rows_now        = tmcr_pkg::DEF_MAP_ROWS;
        win_col         = 0;
        win_row         = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings.
        write_cell(0, 0, 1'b1);
        resolve(0, 0);                  // every corner lands in the same solid tile
        resolve(512, 512);              // agent centred on the tile: push goes positive
        resolve(2000, 512);             // x depth is the smaller one
        resolve(-1000, -1000);          // three corners fall off the map
        write_cell(1, 0, 1'b1);
        resolve(10000, 2000);
        write_cell(63, 63, 1'b1);
        resolve(63 * TILE_Q8 + 1000, 63 * TILE_Q8 + 1000);
        resolve(tmcr_pkg::POS_MIN, tmcr_pkg::POS_MIN);
        resolve(tmcr_pkg::POS_MAX, tmcr_pkg::POS_MAX);
        resolve(tmcr_pkg::POS_MIN, tmcr_pkg::POS_MAX);
        resolve(tmcr_pkg::POS_MAX, tmcr_pkg::POS_MIN);
        write_cell(0, 63, 1'b1);
        write_cell(63, 0, 1'b0);
        resolve(-20000, 63 * TILE_Q8);
        write_cell(0, 0, 1'b0);
        resolve(0, 0);
        write_cell(0, 1, 1'b1);
        write_cell(1, 1, 1'b1);
        resolve(8000, 8000);            // four different tiles around one point
        resolve(16000, 16000);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_setting(1, 14'd64, 14'd64, 1'b0);
                1: apply_setting(16383, 14'd1, 14'd1, 1'b0);
                2: apply_setting($urandom_range(0, 16383), 14'd0, 14'd127, 1'b0);
                3: apply_setting($urandom_range(1, 16383), {7'h5A, 7'd20}, {7'h7F, 7'd9}, 1'b0);
                4: apply_setting(15360, tmcr_pkg::DATA_W'($urandom_range(1, 64)),
                                 tmcr_pkg::DATA_W'($urandom_range(1, 64)), 1'b1);
                default:
                begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                    apply_setting($urandom_range(0, 16383), 14'd64, 14'd64, 1'b0);
                end
            endcase
            repeat (PHASE_WORDS) random_word();
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/tmcr_pkg.sv
hdl/tmcr_channels.sv
hdl/tmcr_ctrl.sv
hdl/tmcr_dp.sv
hdl/tile_map_collision_resolver_core.sv
bench/tmcr_resolve_monitor.sv
bench/tile_map_collision_resolver_core_tb.sv
